// File: rtl/core/addressed_actuator_command_decoder_assert.svh
// assertion macros for the addressed actuator command decoder
// depends on nothing; included by files that carry concurrent checks
`ifndef ADDRESSED_ACTUATOR_COMMAND_DECODER_ASSERT_SVH
`define ADDRESSED_ACTUATOR_COMMAND_DECODER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define AACD_CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aacd check failed (same cycle)");

// next-cycle implication, quiet during reset
`define AACD_CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aacd check failed (next cycle)");

`endif

// File: rtl/core/aacd_pkg.sv
// shared types, constants and helpers for the actuator command decoder
// depends on nothing
package aacd_pkg;

   localparam int WIN_DEPTH = 5;

   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_O = 8'h4F;
   localparam logic [7:0] CHAR_N = 8'h4E;

   localparam logic [7:0] INTEN_LIMIT = 8'd100;
   localparam logic [6:0] INTEN_CAP   = 7'd99;
   localparam logic [6:0] DUTY_FULL   = 7'd100;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_OFF_MS = 1'd1;

   localparam logic [7:0]  DEVICE_ID_RESET   = 8'd28;
   localparam logic [15:0] AUTO_OFF_MS_RESET = 16'd3000;

   // what the window tells the drive logic about the byte now arriving
   typedef struct packed {
      logic       frame;
      logic       state_on;
      logic [7:0] frame_id;
   } win_info_type;

   typedef struct packed {
      logic       drive_on;
      logic [6:0] duty_out;
      logic       frame_seen;
      logic       id_matched;
      logic       timed_out;
   } rsp_type;

   // ascii hex digit to nibble, anything else gives zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] n;
      n = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n = c[3:0];
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         n = 4'(c[3:0] + 4'd9);
      end
      return n;
   endfunction

endpackage

// File: rtl/core/aacd_if.sv
// valid/ready channel interfaces for request and response transactions
// depends on nothing
interface aacd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface aacd_rsp_if;
   logic       valid;
   logic       ready;
   logic       drive_on;
   logic [6:0] duty_out;
   logic       frame_seen;
   logic       id_matched;
   logic       timed_out;

   modport source (output valid, output drive_on, output duty_out, output frame_seen,
                   output id_matched, output timed_out, input ready);
   modport sink (input valid, input drive_on, input duty_out, input frame_seen,
                 input id_matched, input timed_out, output ready);
endinterface

// File: rtl/core/aacd_win_cell.sv
// one stage of the receive window: a byte and its valid flag
// depends on nothing; chained by the top level
module aacd_win_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic [7:0] din_byte,
   input  logic       din_valid,
   output logic [7:0] q_byte,
   output logic       q_valid
);

   logic [7:0] byte_ff;
   logic       valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= din_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= din_byte;
      end
   end

   assign q_byte  = byte_ff;
   assign q_valid = valid_ff;

endmodule

// File: rtl/core/aacd_drive.sv
// drive state, duty and auto-off countdown; forms the response per transaction
// depends on aacd_pkg
module aacd_drive (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic                  func,
   input  logic [7:0]            rx_byte,
   input  aacd_pkg::win_info_type win,
   input  logic [7:0]            device_id,
   input  logic [15:0]           auto_off_ms,
   output aacd_pkg::rsp_type     result
);

   logic        active_ff, active_in;
   logic [6:0]  duty_ff, duty_in;
   logic [15:0] count_ff, count_in;
   logic        frame, matched, expired;
   logic [6:0]  inten;

   always_comb begin
      active_in = active_ff;
      duty_in   = duty_ff;
      count_in  = count_ff;
      frame     = 1'b0;
      matched   = 1'b0;
      expired   = 1'b0;
      inten     = (rx_byte >= aacd_pkg::INTEN_LIMIT) ? aacd_pkg::INTEN_CAP : rx_byte[6:0];
      if (func == aacd_pkg::FUNC_TICK) begin
         if (count_ff != 16'd0) begin
            count_in = count_ff - 16'd1;
            if (count_ff == 16'd1) begin
               active_in = 1'b0;
               expired   = 1'b1;
            end
         end
      end else if (win.frame) begin
         frame = 1'b1;
         if (win.frame_id == device_id) begin
            matched = 1'b1;
            if (win.state_on) begin
               duty_in   = aacd_pkg::DUTY_FULL - inten;
               active_in = 1'b1;
               count_in  = auto_off_ms;
            end else begin
               active_in = 1'b0;
               count_in  = 16'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         duty_ff   <= 7'd0;
         count_ff  <= 16'd0;
      end else if (step_en) begin
         active_ff <= active_in;
         duty_ff   <= duty_in;
         count_ff  <= count_in;
      end
   end

   always_comb begin
      result.drive_on   = active_in;
      result.duty_out   = active_in ? duty_in : 7'd0;
      result.frame_seen = frame;
      result.id_matched = matched;
      result.timed_out  = expired;
   end

endmodule

// File: rtl/core/addressed_actuator_command_decoder.sv
// top level of the addressed actuator command decoder
// depends on aacd_pkg, aacd_if, aacd_win_cell, aacd_drive and the assertion header

// Each request transaction is either a received serial byte (func 0) or a
// one millisecond tick (func 1), and each yields exactly one response
// transaction. The five bytes before the current one sit in a chain of window
// cells; a byte ends a frame when the window reads 'P','O', state, id-hi,
// id-lo and the byte itself is the intensity. A frame whose hex id equals
// device_id switches the drive on (state 'N', duty 100 minus intensity capped
// at 99, countdown loaded from auto_off_ms) or off. Ticks count a running
// countdown down and turn the drive off at zero. One transaction is taken per
// cycle unless the skid entry is full; the response is registered, and a
// two-entry output stage (register plus skid) keeps req ready for one more
// transaction while a response is stalled. csr writes: index 0 device_id,
// index 1 auto_off_ms, applied at any edge with csr_we high, so issue them
// only while no transaction is in flight.
module addressed_actuator_command_decoder (
   input  logic                              clock,
   input  logic                              reset,
   aacd_req_if.sink                          req_ch,
   aacd_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [aacd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [aacd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

`include "addressed_actuator_command_decoder_assert.svh"

   // configuration registers
   logic [7:0]  device_id_ff;
   logic [15:0] auto_off_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= aacd_pkg::DEVICE_ID_RESET;
         auto_off_ff  <= aacd_pkg::AUTO_OFF_MS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            aacd_pkg::CSR_DEVICE_ID:   device_id_ff <= csr_wdata[7:0];
            aacd_pkg::CSR_AUTO_OFF_MS: auto_off_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   logic req_fire, rsp_fire, byte_fire;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   aacd_pkg::rsp_type out_data_ff, out_data_in, skid_data_ff, skid_data_in, result;

   assign req_ch.ready = !skid_valid_ff;
   assign req_fire     = req_ch.valid && !skid_valid_ff;
   assign rsp_fire     = out_valid_ff && rsp_ch.ready;
   assign byte_fire    = req_fire && (req_ch.func == aacd_pkg::FUNC_BYTE);

   // window chain, cell 0 holds the oldest byte
   logic [7:0] win_byte  [aacd_pkg::WIN_DEPTH];
   logic       win_valid [aacd_pkg::WIN_DEPTH];

   for (genvar i = 0; i < aacd_pkg::WIN_DEPTH; i++) begin : g_win
      logic [7:0] feed_byte;
      logic       feed_valid;
      if (i == aacd_pkg::WIN_DEPTH - 1) begin : g_head
         // newest byte enters here
         assign feed_byte  = req_ch.rx_byte;
         assign feed_valid = 1'b1;
      end else begin : g_body
         assign feed_byte  = win_byte[i+1];
         assign feed_valid = win_valid[i+1];
      end
      aacd_win_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (byte_fire),
         .din_byte  (feed_byte),
         .din_valid (feed_valid),
         .q_byte    (win_byte[i]),
         .q_valid   (win_valid[i])
      );
   end

   // frame detect over the window as it stands before this byte shifts in
   aacd_pkg::win_info_type win;

   always_comb begin
      win.frame    = win_valid[0] && win_valid[1] && win_valid[2] && win_valid[3] &&
                     win_valid[4] && (win_byte[0] == aacd_pkg::CHAR_P) &&
                     (win_byte[1] == aacd_pkg::CHAR_O);
      win.state_on = (win_byte[2] == aacd_pkg::CHAR_N);
      win.frame_id = {aacd_pkg::hex_nibble(win_byte[3]), aacd_pkg::hex_nibble(win_byte[4])};
   end

   aacd_drive u_drive (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_fire),
      .func        (req_ch.func),
      .rx_byte     (req_ch.rx_byte),
      .win         (win),
      .device_id   (device_id_ff),
      .auto_off_ms (auto_off_ff),
      .result      (result)
   );

   // output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_fire || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // skid drains first, req is held off meanwhile
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (req_fire) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_fire) begin
         // response stalled, park the new one
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.drive_on   = out_data_ff.drive_on;
   assign rsp_ch.duty_out   = out_data_ff.duty_out;
   assign rsp_ch.frame_seen = out_data_ff.frame_seen;
   assign rsp_ch.id_matched = out_data_ff.id_matched;
   assign rsp_ch.timed_out  = out_data_ff.timed_out;

   // checks
   `AACD_CHECK_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   `AACD_CHECK_NEXT(a_stall_parks, clock, reset, req_fire && out_valid_ff && !rsp_ch.ready,
                    skid_valid_ff && out_valid_ff)
   `AACD_CHECK_NOW(a_duty_tracks_drive, clock, reset, rsp_ch.valid,
                   rsp_ch.drive_on == (rsp_ch.duty_out != 7'd0))
   `AACD_CHECK_NOW(a_match_in_frame, clock, reset, rsp_ch.valid && rsp_ch.id_matched,
                   rsp_ch.frame_seen)
   `AACD_CHECK_NOW(a_timeout_is_off, clock, reset, rsp_ch.valid && rsp_ch.timed_out,
                   !rsp_ch.drive_on && !rsp_ch.frame_seen)

endmodule

// File: test/aacd_tb_checker.sv
`timescale 1ns / 100ps
// response checker for the addressed actuator command decoder: watches both channels
// and the csr port, predicts each response and compares it. depends on aacd_pkg, aacd_if
module aacd_tb_checker
   import aacd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   aacd_req_if                    req_mon,
   aacd_rsp_if                    rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     fail_count,
   output int                     pending
);

   localparam logic [7:0] ASC_0       = 8'h30;
   localparam logic [7:0] ASC_9       = 8'h39;
   localparam logic [7:0] ASC_UPPER_A = 8'h41;
   localparam logic [7:0] ASC_UPPER_F = 8'h46;
   localparam logic [7:0] ASC_LOWER_A = 8'h61;
   localparam logic [7:0] ASC_LOWER_F = 8'h66;

   // predicted state of the decoder
   logic [7:0]  win [WIN_DEPTH];
   int          win_fill;
   logic        drive_active;
   logic [6:0]  drive_duty;
   logic [15:0] off_countdown;
   logic [7:0]  cfg_device_id;
   logic [15:0] cfg_auto_off;

   rsp_type     expected_drive_q[$];
   rsp_type     want;

   function automatic logic [3:0] digit_value(input logic [7:0] c);
      if (c >= ASC_0 && c <= ASC_9) return 4'(c - ASC_0);
      if (c >= ASC_UPPER_A && c <= ASC_UPPER_F) return 4'(c - ASC_UPPER_A + 8'd10);
      if (c >= ASC_LOWER_A && c <= ASC_LOWER_F) return 4'(c - ASC_LOWER_A + 8'd10);
      return 4'd0;
   endfunction

   // advance the predicted state by one request and return the response it gives
   function automatic rsp_type apply_decoder_item(input logic f, input logic [7:0] b);
      rsp_type    r;
      logic [7:0] frame_id;
      logic [7:0] inten;
      r = '0;
      if (f == FUNC_TICK) begin
         if (off_countdown != 16'd0) begin
            off_countdown = off_countdown - 16'd1;
            if (off_countdown == 16'd0) begin
               drive_active = 1'b0;
               r.timed_out  = 1'b1;
            end
         end
      end else begin
         if (win_fill >= WIN_DEPTH && win[0] == CHAR_P && win[1] == CHAR_O) begin
            frame_id     = {digit_value(win[3]), digit_value(win[4])};
            r.frame_seen = 1'b1;
            if (frame_id == cfg_device_id) begin
               r.id_matched = 1'b1;
               if (win[2] == CHAR_N) begin
                  inten         = (b >= INTEN_LIMIT) ? {1'b0, INTEN_CAP} : b;
                  drive_duty    = DUTY_FULL - inten[6:0];
                  drive_active  = 1'b1;
                  off_countdown = cfg_auto_off;
               end else begin
                  drive_active  = 1'b0;
                  off_countdown = 16'd0;
               end
            end
         end
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            win[i] = win[i + 1];
         end
         win[WIN_DEPTH - 1] = b;
         if (win_fill < WIN_DEPTH) win_fill++;
      end
      r.drive_on = drive_active;
      r.duty_out = drive_active ? drive_duty : 7'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win[i] = 8'd0;
         end
         win_fill      = 0;
         drive_active  = 1'b0;
         drive_duty    = 7'd0;
         off_countdown = 16'd0;
         cfg_device_id = DEVICE_ID_RESET;
         cfg_auto_off  = AUTO_OFF_MS_RESET;
         expected_drive_q.delete();
         fail_count    = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_ID:   cfg_device_id = csr_wdata[7:0];
               CSR_AUTO_OFF_MS: cfg_auto_off  = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_drive_q.push_back(apply_decoder_item(req_mon.func, req_mon.rx_byte));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_drive_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t: response with nothing outstanding", $realtime);
               end
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_mon.drive_on !== want.drive_on || rsp_mon.duty_out !== want.duty_out ||
                   rsp_mon.frame_seen !== want.frame_seen ||
                   rsp_mon.id_matched !== want.id_matched ||
                   rsp_mon.timed_out !== want.timed_out) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch expected on=%0b duty=%0d frame=%0b match=%0b tmo=%0b",
                              $realtime, want.drive_on, want.duty_out, want.frame_seen,
                              want.id_matched, want.timed_out);
                     $display("%0t:          actual   on=%0b duty=%0d frame=%0b match=%0b tmo=%0b",
                              $realtime, rsp_mon.drive_on, rsp_mon.duty_out,
                              rsp_mon.frame_seen, rsp_mon.id_matched, rsp_mon.timed_out);
                  end
               end
            end
         end
      end
      pending = expected_drive_q.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// top of the addressed actuator command decoder testbench: clock, reset, stimulus, verdict
// depends on aacd_pkg, aacd_if, the decoder rtl and aacd_tb_checker
module tb;
   import aacd_pkg::*;

   localparam logic [7:0] ASC_0       = 8'h30;
   localparam logic [7:0] ASC_UPPER_A = 8'h41;
   localparam logic [7:0] ASC_LOWER_A = 8'h61;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     fail_count;
   int                     pending;

   aacd_req_if req_ch ();
   aacd_rsp_if rsp_ch ();

   // stimulus-side knobs
   logic        req_gaps;       // sender inserts random idle cycles
   logic        rsp_gaps;       // receiver drops ready at random
   logic        hold_off_req;   // asks the receiver for one long stall
   int          items_sent;
   logic [7:0]  cur_device_id;  // last device id written, used to build matching frames

   addressed_actuator_command_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aacd_tb_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin
      #2_000_000;
      $display("** addressed_actuator_command_decoder: FAILED **");
      $finish;
   end

   // response side: random back-pressure, plus one long stall counted here on request
   initial begin
      int hold_left;
      hold_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = 60;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= !rsp_gaps || ($urandom_range(99) >= 8);
         end
      end
   end

   // ascii hex digit for a nibble, either case
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
      if (nib < 4'd10) return ASC_0 + 8'(nib);
      return (lower ? ASC_LOWER_A : ASC_UPPER_A) + 8'(nib) - 8'd10;
   endfunction

   // one request transaction; called and returns at a falling edge
   task automatic send_item(input logic f, input logic [7:0] b);
      while (req_gaps && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.func    <= f;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      // byte field is don't-care on ticks, so keep it moving
      send_item(FUNC_TICK, 8'($urandom_range(255)));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_item(FUNC_BYTE, s[i]);
      end
   endtask

   // drop valid and let every outstanding response come back
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // both registers, back to back, only once the decoder is drained
   task automatic write_config(input logic [7:0] dev_id, input logic [15:0] off_ms);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_DEVICE_ID;
      // upper bits are outside the register and must be dropped
      csr_wdata <= {8'($urandom_range(255)), dev_id};
      @(negedge clock);
      csr_index <= CSR_AUTO_OFF_MS;
      csr_wdata <= off_ms;
      @(negedge clock);
      csr_we    <= 1'b0;
      @(negedge clock);
      cur_device_id = dev_id;
   endtask

   // one well-formed frame with random content, mostly addressed to this node
   task automatic send_random_frame();
      int         pick;
      logic [7:0] state_b;
      logic [7:0] id_hi;
      logic [7:0] id_lo;
      logic [7:0] inten;
      state_b = ($urandom_range(9) < 7) ? CHAR_N : 8'($urandom_range(255));
      pick    = $urandom_range(99);
      if (pick < 70) begin
         id_hi = hex_char(cur_device_id[7:4], 1'($urandom_range(1)));
         id_lo = hex_char(cur_device_id[3:0], 1'($urandom_range(1)));
      end else if (pick < 85) begin
         id_hi = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
         id_lo = hex_char(4'($urandom_range(15)), 1'($urandom_range(1)));
      end else begin
         // arbitrary characters, mostly non-hex so the nibble falls back to zero
         id_hi = 8'($urandom_range(255));
         id_lo = 8'($urandom_range(255));
      end
      inten = $urandom_range(1) ? 8'($urandom_range(110)) : 8'($urandom_range(255));
      send_item(FUNC_BYTE, CHAR_P);
      send_item(FUNC_BYTE, CHAR_O);
      send_item(FUNC_BYTE, state_b);
      send_item(FUNC_BYTE, id_hi);
      send_item(FUNC_BYTE, id_lo);
      send_item(FUNC_BYTE, inten);
   endtask

   // mix of frames, tick bursts, truncated frames and line noise
   task automatic run_random(input int count);
      int start;
      int pick;
      int k;
      start = items_sent;
      while (items_sent - start < count) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            send_random_frame();
         end else if (pick < 70) begin
            k = $urandom_range(12, 1);
            repeat (k) send_tick();
         end else if (pick < 85) begin
            // frame cut short by noise
            send_item(FUNC_BYTE, CHAR_P);
            send_item(FUNC_BYTE, CHAR_O);
            k = $urandom_range(3, 1);
            repeat (k) send_item(FUNC_BYTE, 8'($urandom_range(255)));
         end else begin
            send_item(FUNC_BYTE, 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_DEVICE_ID;
      csr_wdata      = '0;
      req_ch.valid   = 1'b0;
      req_ch.func    = FUNC_BYTE;
      req_ch.rx_byte = 8'd0;
      req_gaps       = 1'b1;
      rsp_gaps       = 1'b1;
      hold_off_req   = 1'b0;
      items_sent     = 0;
      cur_device_id  = DEVICE_ID_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset config: device id 0x1C, auto-off 3000
      send_tick();                    // countdown stopped, nothing changes
      send_text("PON1C");             // too few bytes yet for any frame to end
      send_item(FUNC_BYTE, 8'd0);     // intensity zero, full duty
      send_tick();                    // running countdown steps down
      send_text("PON1cP");            // lower-case id, intensity 'P'; that P opens the next frame
      send_text("ONGz");              // non-hex id reads as zero, not this node
      send_item(FUNC_BYTE, 8'd99);    // unmatched frame leaves the drive alone
      send_text("POF1C");             // off frame for this node
      send_item(FUNC_BYTE, 8'd100);

      // long receiver stall while the sender keeps offering, so req ready drops
      hold_off_req = 1'b1;
      run_random(250);

      // lowest settings: id 0, countdown of one tick
      write_config(8'h00, 16'd1);
      send_text("PONgz");             // non-hex id matches node zero
      send_item(FUNC_BYTE, 8'd100);   // intensity capped at 99
      send_tick();                    // expires at once
      send_tick();                    // already stopped
      run_random(250);

      // zero auto-off: drive stays on until an off frame
      write_config(8'hFF, 16'd0);
      send_text("PONFf");
      send_item(FUNC_BYTE, 8'd255);
      send_tick();
      send_tick();
      run_random(200);

      // longest countdown
      write_config(8'($urandom_range(255)), 16'hFFFF);
      run_random(200);

      // short countdowns so ticks keep expiring it
      write_config(8'($urandom_range(255)), 16'($urandom_range(25, 2)));
      run_random(150);
      // sender holds off until every response is back
      wait_idle();
      // stretch with no idling on either side
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_random(150);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      run_random(100);

      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("** addressed_actuator_command_decoder: PASSED **");
      end else begin
         $display("** addressed_actuator_command_decoder: FAILED **");
      end
      $finish;
   end

endmodule
